// ===== hdl/dmclf_pkg.sv =====
// ----------------------------------------------------------------------------
// dmclf_pkg: shared constants and types for the direct-mapped line-fill cache
//
// Geometry of the tag and data stores, field slicing widths and the
// one-hot encoding of the refill controller.
// ----------------------------------------------------------------------------
package dmclf_pkg;

  // Cache geometry
  localparam int SET_BITS        = 9;
  localparam int LINE_BYTES_LOG2 = 5;
  localparam int ADDR_BITS       = 32;
  localparam int WORD_BITS       = 32;

  localparam int NUM_SETS        = 1 << SET_BITS;
  localparam int TAG_WIDTH       = ADDR_BITS - SET_BITS - LINE_BYTES_LOG2;
  localparam int TAG_ENTRY_BITS  = TAG_WIDTH + 1;
  localparam int WORD_IDX_BITS   = SET_BITS + LINE_BYTES_LOG2 - 2;
  localparam int NUM_WORDS       = 1 << WORD_IDX_BITS;
  localparam int WORDS_PER_LINE  = 1 << (LINE_BYTES_LOG2 - 2);
  localparam int WORDS_LEFT_BITS = LINE_BYTES_LOG2 - 1;

  // Latency register
  localparam int              LAT_BITS      = 4;
  localparam logic [LAT_BITS-1:0] LATENCY_RESET = LAT_BITS'(6);

  // Refill controller, one-hot
  typedef enum logic [3:0] {
    ST_READY      = 4'b0001,
    ST_CLAIM      = 4'b0010,
    ST_FILLING    = 4'b0100,
    ST_UPDATE_TAG = 4'b1000
  } ctrl_state_t;

endpackage

// ===== hdl/direct_mapped_cache_line_fill.sv =====
// ----------------------------------------------------------------------------
// direct_mapped_cache_line_fill: direct-mapped read cache with blocking refill
//
// Input items (in_valid/in_ready) carry one clock step of the cache:
//   access_address, restart and fill_word, where fill_word is the memory word
//   at next_fill_address of the previous result.
// Results (out_valid/out_ready), one per item: hit, read_word (zero on a
//   miss), ready_res, fill_taken, next_fill_address.
// cfg_we writes cfg_wdata into memory_latency; write only with no item in flight.
// An accepted item reads both stores into registers and sets eval; while eval is
//   high the result is computed and the stores written back, and out_valid rises.
//   No new item is taken while eval is high, so an item is not accepted before the
//   last one is written back: the read-then-write-back pass over the stores sets the pace.
// Reset returns the controller to ready and sweeps the tag store to invalid,
//   one set per cycle: in_ready stays low until all 512 sets are cleared after rst falls.
// While out_valid is high and out_ready low the result holds and no new item
//   is accepted.
// ----------------------------------------------------------------------------
module direct_mapped_cache_line_fill
  import dmclf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // config
  input  logic                 cfg_we,
  input  logic [LAT_BITS-1:0]  cfg_wdata,
  // item input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ADDR_BITS-1:0] access_address,
  input  logic                 restart,
  input  logic [WORD_BITS-1:0] fill_word,
  // result output
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic [WORD_BITS-1:0] read_word,
  output logic                 ready_res,
  output logic                 fill_taken,
  output logic [ADDR_BITS-1:0] next_fill_address
);

  // Stores
  logic [TAG_ENTRY_BITS-1:0] tag_mem  [NUM_SETS];
  logic [WORD_BITS-1:0]      data_mem [NUM_WORDS];
  logic [TAG_ENTRY_BITS-1:0] tag_rd;
  logic [WORD_BITS-1:0]      data_rd;

  // Control registers
  ctrl_state_t                state, state_next;
  logic [WORDS_LEFT_BITS-1:0] words_left, words_left_next;
  logic [ADDR_BITS-1:0]       fill_pointer, fill_pointer_next;
  logic [TAG_WIDTH-1:0]       pending_tag, pending_tag_next;
  logic [SET_BITS-1:0]        pending_set, pending_set_next;
  logic [LAT_BITS-1:0]        wait_count, wait_count_next;
  logic [LAT_BITS-1:0]        memory_latency;
  logic                       eval;
  logic                       clearing;
  logic [SET_BITS-1:0]        clr_idx;

  // Latched item
  logic [ADDR_BITS-1:0] item_addr;
  logic                 item_restart;
  logic [WORD_BITS-1:0] item_word;

  // Evaluation signals
  logic                      in_accept;
  logic [TAG_WIDTH-1:0]      item_tag;
  logic [SET_BITS-1:0]       item_set;
  logic                      hit_now;
  logic                      taken_now;
  logic                      data_we;
  logic                      tag_upd;
  logic                      tag_we;
  logic [SET_BITS-1:0]       tag_waddr;
  logic [TAG_ENTRY_BITS-1:0] tag_wdata;

  assign in_ready  = !eval && !clearing && (!out_valid || out_ready);
  assign in_accept = in_valid && in_ready;

  assign item_tag = item_addr[ADDR_BITS-1 -: TAG_WIDTH];
  assign item_set = item_addr[LINE_BYTES_LOG2 +: SET_BITS];
  assign hit_now  = (tag_rd == {1'b1, item_tag}) && !item_restart;

  // Refill controller next state
  always_comb begin
    state_next        = state;
    words_left_next   = words_left;
    fill_pointer_next = fill_pointer;
    pending_tag_next  = pending_tag;
    pending_set_next  = pending_set;
    wait_count_next   = wait_count;
    taken_now         = 1'b0;
    tag_upd           = 1'b0;
    case (state)
      ST_READY: begin
        if (!hit_now) begin
          words_left_next   = WORDS_LEFT_BITS'(WORDS_PER_LINE);
          fill_pointer_next = {item_addr[ADDR_BITS-1:LINE_BYTES_LOG2],
                               {LINE_BYTES_LOG2{1'b0}}};
          pending_tag_next  = item_tag;
          pending_set_next  = item_set;
          state_next        = ST_CLAIM;
        end
      end
      ST_CLAIM: begin
        wait_count_next = memory_latency;
        state_next      = ST_FILLING;
      end
      ST_FILLING: begin
        if (wait_count == '0) begin
          if (words_left != '0) begin
            taken_now         = 1'b1;
            words_left_next   = words_left - WORDS_LEFT_BITS'(1);
            fill_pointer_next = fill_pointer + ADDR_BITS'(4);
            if (words_left == WORDS_LEFT_BITS'(1)) begin
              state_next = ST_UPDATE_TAG;
            end
          end
        end else begin
          wait_count_next = wait_count - LAT_BITS'(1);
        end
      end
      ST_UPDATE_TAG: begin
        tag_upd    = 1'b1;
        state_next = ST_READY;
      end
      default: begin
        state_next = ST_READY;
      end
    endcase
  end

  assign data_we   = eval && taken_now;
  assign tag_we    = clearing || (eval && tag_upd);
  assign tag_waddr = clearing ? clr_idx : pending_set;
  assign tag_wdata = clearing ? '0 : {1'b1, pending_tag};

  // Tag store: one write, one registered read
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    if (in_accept) begin
      tag_rd <= tag_mem[access_address[LINE_BYTES_LOG2 +: SET_BITS]];
    end
  end

  // Data store: one write, one registered read
  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[fill_pointer[2 +: WORD_IDX_BITS]] <= item_word;
    end
    if (in_accept) begin
      data_rd <= data_mem[access_address[2 +: WORD_IDX_BITS]];
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_addr    <= access_address;
      item_restart <= restart;
      item_word    <= fill_word;
    end
  end

  // Control state, config and tag sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_READY;
      words_left     <= '0;
      fill_pointer   <= '0;
      pending_tag    <= '0;
      pending_set    <= '0;
      wait_count     <= '0;
      memory_latency <= LATENCY_RESET;
      eval           <= 1'b0;
      clearing       <= 1'b1;
      clr_idx        <= '0;
    end else begin
      if (cfg_we) begin
        memory_latency <= cfg_wdata;
      end
      if (clearing) begin
        clr_idx <= clr_idx + SET_BITS'(1);
        if (clr_idx == SET_BITS'(NUM_SETS - 1)) begin
          clearing <= 1'b0;
        end
      end
      eval <= in_accept;
      if (eval) begin
        state        <= state_next;
        words_left   <= words_left_next;
        fill_pointer <= fill_pointer_next;
        pending_tag  <= pending_tag_next;
        pending_set  <= pending_set_next;
        wait_count   <= wait_count_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eval) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval) begin
      hit               <= hit_now;
      read_word         <= hit_now ? data_rd : '0;
      ready_res         <= (state_next == ST_READY);
      fill_taken        <= taken_now;
      next_fill_address <= fill_pointer_next;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the direct-mapped line-fill cache
//
// Drives access items through the valid/ready input channel and checks every
// result against a lit row's table entry or else a cycle-step model of the
// cache kept inside the bench. A short table walks one full refill, hits,
// restart on a tag match, a stale hit while a line is being refilled and a
// miss while busy. Random phases then work a small pool of conflicting lines
// under varied memory latency and varied sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb
  import dmclf_pkg::*;
();

  // Result of one cache step
  typedef struct packed {
    logic                 hit;
    logic [WORD_BITS-1:0] read_word;
    logic                 ready_res;
    logic                 fill_taken;
    logic [ADDR_BITS-1:0] next_fill_address;
  } cache_result_t;

  // One row of directed stimulus; want is used only when lit is set
  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic                 restart_req;
    logic [WORD_BITS-1:0] word;
    logic [3:0]           reps;
    logic                 lit;
    cache_result_t        want;
  } access_row_t;

  localparam int NUM_DIRECTED    = 22;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int POOL_LINES      = 8;
  localparam logic [LAT_BITS-1:0] PHASE_LATENCY [NUM_PHASES] =
    '{4'd0, 4'd15, 4'd3, 4'd0, 4'd15, 4'd9, 4'd1, 4'd6};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [LAT_BITS-1:0]  cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ADDR_BITS-1:0] access_address = '0;
  logic                 restart = 1'b0;
  logic [WORD_BITS-1:0] fill_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 hit;
  logic [WORD_BITS-1:0] read_word;
  logic                 ready_res;
  logic                 fill_taken;
  logic [ADDR_BITS-1:0] next_fill_address;

  // Bench model of the cache
  ctrl_state_t                ctl_state;
  logic [TAG_ENTRY_BITS-1:0]  tag_mem [NUM_SETS];
  logic [WORD_BITS-1:0]       data_mem [NUM_WORDS];
  int                         words_left;
  logic [ADDR_BITS-1:0]       fill_ptr;
  logic [TAG_WIDTH-1:0]       pend_tag;
  logic [SET_BITS-1:0]        pend_set;
  logic [LAT_BITS-1:0]        wait_cnt;
  logic [LAT_BITS-1:0]        mem_latency;

  cache_result_t        pending_results [$];
  cache_result_t        oldest_result;
  int                   mismatch_count = 0;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  logic [ADDR_BITS-1:0] line_pool [POOL_LINES];

  // Directed table: first refill at reset latency, hits, forced refill,
  // stale hits while the same set refills, a conflicting-tag miss that starts a refill
  access_row_t directed_rows [NUM_DIRECTED] = '{
    '{32'h0000_0040, 1'b0, 32'h0000_0000, 4'd1, 1'b1, '{1'b0, 32'h0, 1'b0, 1'b0, 32'h40}},
    '{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 4'd1, 1'b1, '{1'b0, 32'h0, 1'b0, 1'b0, 32'h40}},
    '{32'h0000_4040, 1'b0, 32'hDEAD_BEEF, 4'd6, 1'b1, '{1'b0, 32'h0, 1'b0, 1'b0, 32'h40}},
    '{32'h0000_0040, 1'b0, 32'h0000_0000, 4'd1, 1'b1, '{1'b0, 32'h0, 1'b0, 1'b1, 32'h44}},
    '{32'h0000_0044, 1'b0, 32'hFFFF_FFFF, 4'd1, 1'b1, '{1'b0, 32'h0, 1'b0, 1'b1, 32'h48}},
    '{32'h0000_0048, 1'b0, 32'h1234_5678, 4'd1, 1'b1, '{1'b0, 32'h0, 1'b0, 1'b1, 32'h4C}},
    '{32'h0000_004C, 1'b0, 32'h9ABC_DEF0, 4'd1, 1'b1, '{1'b0, 32'h0, 1'b0, 1'b1, 32'h50}},
    '{32'h0000_0050, 1'b0, 32'h0F0F_0F0F, 4'd1, 1'b1, '{1'b0, 32'h0, 1'b0, 1'b1, 32'h54}},
    '{32'h0000_0054, 1'b0, 32'hF0F0_F0F0, 4'd1, 1'b1, '{1'b0, 32'h0, 1'b0, 1'b1, 32'h58}},
    '{32'h0000_0058, 1'b0, 32'h5555_5555, 4'd1, 1'b1, '{1'b0, 32'h0, 1'b0, 1'b1, 32'h5C}},
    '{32'h0000_005C, 1'b0, 32'hAAAA_AAAA, 4'd1, 1'b1, '{1'b0, 32'h0, 1'b0, 1'b1, 32'h60}},
    '{32'h0000_0040, 1'b0, 32'h0000_0000, 4'd1, 1'b1, '{1'b0, 32'h0, 1'b1, 1'b0, 32'h60}},
    '{32'h0000_0044, 1'b0, 32'h0000_0000, 4'd1, 1'b1,
      '{1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h60}},
    '{32'h0000_005F, 1'b0, 32'h0000_0000, 4'd1, 1'b1,
      '{1'b1, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'h60}},
    '{32'h0000_0040, 1'b1, 32'h0000_0000, 4'd1, 1'b1, '{1'b0, 32'h0, 1'b0, 1'b0, 32'h40}},
    '{32'h0000_0048, 1'b0, 32'h0000_0000, 4'd1, 1'b1,
      '{1'b1, 32'h1234_5678, 1'b0, 1'b0, 32'h40}},
    '{32'h0000_0040, 1'b0, 32'h1357_9BDF, 4'd6, 1'b1, '{1'b1, 32'h0, 1'b0, 1'b0, 32'h40}},
    '{32'h0000_0040, 1'b0, 32'hA5A5_A5A5, 4'd1, 1'b1, '{1'b1, 32'h0, 1'b0, 1'b1, 32'h44}},
    '{32'h0000_0040, 1'b0, 32'h5A5A_5A5A, 4'd1, 1'b1,
      '{1'b1, 32'hA5A5_A5A5, 1'b0, 1'b1, 32'h48}},
    '{32'h7FFF_FFE0, 1'b0, 32'h3C3C_3C3C, 4'd6, 1'b0, '0},
    '{32'h8000_0000, 1'b0, 32'h0000_0000, 4'd1, 1'b0, '0},
    '{32'h0000_4040, 1'b0, 32'h0000_0000, 4'd1, 1'b1, '{1'b0, 32'h0, 1'b0, 1'b0, 32'h4040}}
  };

  direct_mapped_cache_line_fill u_top (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .access_address    (access_address),
    .restart           (restart),
    .fill_word         (fill_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .hit               (hit),
    .read_word         (read_word),
    .ready_res         (ready_res),
    .fill_taken        (fill_taken),
    .next_fill_address (next_fill_address)
  );

  always #4 clk = ~clk;

  // One cache step: lookup first, then advance the refill controller
  function automatic cache_result_t predict_access(input logic [ADDR_BITS-1:0] addr,
                                                   input logic restart_req,
                                                   input logic [WORD_BITS-1:0] word);
    logic [SET_BITS-1:0]  set_i;
    logic [TAG_WIDTH-1:0] tag_i;
    cache_result_t        r;
    set_i = addr[LINE_BYTES_LOG2 +: SET_BITS];
    tag_i = addr[ADDR_BITS-1 -: TAG_WIDTH];
    r.hit = (tag_mem[set_i] == {1'b1, tag_i}) && !restart_req;
    r.read_word = r.hit ? data_mem[addr[WORD_IDX_BITS+1:2]] : '0;
    r.fill_taken = 1'b0;
    case (ctl_state)
      ST_READY: begin
        // miss or restart starts a refill of the whole line
        if (!r.hit) begin
          words_left = WORDS_PER_LINE;
          fill_ptr   = {addr[ADDR_BITS-1:LINE_BYTES_LOG2], LINE_BYTES_LOG2'(0)};
          pend_tag   = tag_i;
          pend_set   = set_i;
          ctl_state  = ST_CLAIM;
        end
      end
      ST_CLAIM: begin
        wait_cnt  = mem_latency;
        ctl_state = ST_FILLING;
      end
      ST_FILLING: begin
        if (wait_cnt == 0) begin
          if (words_left != 0) begin
            data_mem[fill_ptr[WORD_IDX_BITS+1:2]] = word;
            r.fill_taken = 1'b1;
            words_left--;
            fill_ptr += 4;
            if (words_left == 0) ctl_state = ST_UPDATE_TAG;
          end
        end else begin
          wait_cnt--;
        end
      end
      default: begin
        tag_mem[pend_set] = {1'b1, pend_tag};
        ctl_state = ST_READY;
      end
    endcase
    r.ready_res = (ctl_state == ST_READY);
    r.next_fill_address = fill_ptr;
    return r;
  endfunction

  // New pool line, biased toward a few sets so lines evict each other
  function automatic logic [ADDR_BITS-1:0] fresh_line();
    logic [SET_BITS-1:0] s;
    case ($urandom_range(0, 3))
      0: s = SET_BITS'(2);
      1: s = '0;
      2: s = '1;
      default: s = SET_BITS'($urandom);
    endcase
    return {TAG_WIDTH'($urandom), s, LINE_BYTES_LOG2'(0)};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Present one item, hold it until taken, then queue its result
  task automatic put_item(input logic [ADDR_BITS-1:0] a, input logic r,
                          input logic [WORD_BITS-1:0] w, input logic lit,
                          input cache_result_t want);
    cache_result_t exp_r;
    bit            taken;
    exp_r = predict_access(a, r, w);
    if (lit) exp_r = want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    access_address <= a;
    restart        <= r;
    fill_word      <= w;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    pending_results.push_back(exp_r);
  endtask

  // Mostly pool lines with a memory-like fill word; some noise
  task automatic next_random_item(output logic [ADDR_BITS-1:0] a, output logic r,
                                  output logic [WORD_BITS-1:0] w);
    if ($urandom_range(0, 49) == 0) line_pool[$urandom_range(2, POOL_LINES-1)] = fresh_line();
    if ($urandom_range(0, 9) == 0) begin
      a = $urandom;
      r = 1'($urandom_range(0, 1));
    end else begin
      a = line_pool[$urandom_range(0, POOL_LINES-1)] | ADDR_BITS'($urandom_range(0, 31));
      r = ($urandom_range(0, 99) < 6);
    end
    if ($urandom_range(0, 9) == 0) w = $urandom;
    else w = fill_ptr * 32'h9E37_79B1 ^ {fill_ptr[15:0], fill_ptr[31:16]};
  endtask

  // Drain, then write the latency register while nothing is in flight
  task automatic set_latency(input logic [LAT_BITS-1:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mem_latency = v;
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Result check, sampled mid-cycle ahead of the accepting edge
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no pending item", next_fill_address, '0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (hit !== oldest_result.hit)
          report_mismatch("hit", 32'(hit), 32'(oldest_result.hit));
        if (read_word !== oldest_result.read_word)
          report_mismatch("read_word", read_word, oldest_result.read_word);
        if (ready_res !== oldest_result.ready_res)
          report_mismatch("ready_res", 32'(ready_res), 32'(oldest_result.ready_res));
        if (fill_taken !== oldest_result.fill_taken)
          report_mismatch("fill_taken", 32'(fill_taken), 32'(oldest_result.fill_taken));
        if (next_fill_address !== oldest_result.next_fill_address)
          report_mismatch("next_fill_address", next_fill_address,
                          oldest_result.next_fill_address);
      end
    end
  end

  // Main sequence
  initial begin
    logic [ADDR_BITS-1:0] a;
    logic                 r;
    logic [WORD_BITS-1:0] w;
    ctl_state   = ST_READY;
    words_left  = 0;
    fill_ptr    = '0;
    pend_tag    = '0;
    pend_set    = '0;
    wait_cnt    = '0;
    mem_latency = LATENCY_RESET;
    foreach (tag_mem[i]) tag_mem[i] = '0;
    foreach (data_mem[i]) data_mem[i] = '0;
    line_pool[0] = '0;
    line_pool[1] = {{(ADDR_BITS-LINE_BYTES_LOG2){1'b1}}, LINE_BYTES_LOG2'(0)};
    for (int i = 2; i < POOL_LINES; i++) line_pool[i] = fresh_line();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table at reset latency
    foreach (directed_rows[i]) begin
      repeat (directed_rows[i].reps)
        put_item(directed_rows[i].addr, directed_rows[i].restart_req,
                 directed_rows[i].word, directed_rows[i].lit, directed_rows[i].want);
    end

    // random phases: latency setting and idling style change per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_latency(PHASE_LATENCY[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        next_random_item(a, r, w);
        put_item(a, r, w, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  // Hang guard
  initial begin
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

// ===== direct_mapped_cache_line_fill.f =====
hdl/dmclf_pkg.sv
hdl/direct_mapped_cache_line_fill.sv
tb/sv/tb.sv
